>>> rtl/core/fecho_pkg.sv
// Package for the feedback echo block: sizes, register indexes, microcode format,
// the microprogram and the Q15 helper functions.
// No dependencies.
`timescale 1ns / 1ps

package fecho_pkg;

    localparam int MAX_DELAY  = 4096;
    localparam int PTR_W      = $clog2(MAX_DELAY);
    localparam int LEN_W      = $clog2(MAX_DELAY + 1);
    localparam int SMP_W      = 16;
    localparam int GAIN_W     = 15;
    localparam int LEVEL_W    = 4;
    localparam int DLEN_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ECHO_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_GAIN      = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_LVL_FB,
        MOP_FBG_T1,
        MOP_TAP_D,
        MOP_LVL_T2,
        MOP_DIR_P0
    } mop_t;

    typedef enum logic {
        CND_NONE,
        CND_OUT_FREE
    } cond_t;

    typedef struct packed {
        mop_t              mul1;
        mop_t              mul2;
        logic              fb_ld;
        logic              p0_ld;
        logic              mem_wr;
        logic              out_ld;
        cond_t             cond;
        logic              last;
        logic [STEP_W-1:0] nxt;
    } ucode_t;

    localparam ucode_t UCODE_NOP = '{MOP_NONE, MOP_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                                     CND_NONE, 1'b1, 2'd0};

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t cw;
        case (step)
            2'd0: cw = '{MOP_LVL_FB, MOP_TAP_D,  1'b0, 1'b0, 1'b0, 1'b0,
                         CND_NONE, 1'b0, 2'd1};
            2'd1: cw = '{MOP_FBG_T1, MOP_LVL_T2, 1'b1, 1'b0, 1'b0, 1'b0,
                         CND_NONE, 1'b0, 2'd2};
            2'd2: cw = '{MOP_NONE,   MOP_NONE,   1'b0, 1'b1, 1'b1, 1'b0,
                         CND_NONE, 1'b0, 2'd3};
            2'd3: cw = '{MOP_DIR_P0, MOP_NONE,   1'b0, 1'b0, 1'b0, 1'b1,
                         CND_OUT_FREE, 1'b1, 2'd0};
            default: cw = UCODE_NOP;
        endcase
        return cw;
    endfunction

    // level/10 in Q15, truncated; levels above ten act as ten
    function automatic logic [GAIN_W-1:0] level_frac(input logic [LEVEL_W-1:0] level);
        logic [GAIN_W-1:0] f;
        case (level)
            4'd0:    f = 15'd0;
            4'd1:    f = 15'd3276;
            4'd2:    f = 15'd6553;
            4'd3:    f = 15'd9830;
            4'd4:    f = 15'd13106;
            4'd5:    f = 15'd16383;
            4'd6:    f = 15'd19660;
            4'd7:    f = 15'd22936;
            4'd8:    f = 15'd26213;
            4'd9:    f = 15'd29490;
            default: f = 15'd32767;
        endcase
        return f;
    endfunction

    // Q15 product, floor rounding; result known to fit 16 bits
    function automatic logic signed [SMP_W-1:0] qmul(input logic signed [SMP_W:0] a,
                                                      input logic signed [SMP_W:0] b);
        logic signed [2*SMP_W+1:0] p;
        p = a * b;
        return p[SMP_W+14:15];
    endfunction

    function automatic logic signed [SMP_W-1:0] sat_add(input logic signed [SMP_W-1:0] a,
                                                         input logic signed [SMP_W-1:0] b);
        logic signed [SMP_W:0] s;
        logic signed [SMP_W-1:0] r;
        s = {a[SMP_W-1], a} + {b[SMP_W-1], b};
        if (s[SMP_W] != s[SMP_W-1]) begin
            r = s[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
        end else begin
            r = s[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/fecho_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module fecho_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/feedback_echo_top.sv
// Feedback comb echo, top level: config registers, microcode sequencer, Q15 datapath.
// Depends on fecho_pkg and fecho_ram.
// Sequence: the input beat is taken in idle, then the 4 microcode steps run; the result is registered
// in the last step, which stalls until the output is free. No new beat is taken until the program ends.
// The result register is separate, so the next beat is taken while a result waits.
// Reset (aresetn, sync): control/config registers to defaults; delay memory reads zero until written.
`timescale 1ns / 1ps

module feedback_echo_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fecho_pkg::SMP_W-1:0]         s_tdata,   // [15:0] sample_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fecho_pkg::SMP_W-1:0]         m_tdata,   // [15:0] sample_out
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fecho_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fecho_pkg::CFG_DATA_W-1:0]    cfg_data
);

    fecho_pkg::state_t state_reg, state_next;
    logic [fecho_pkg::STEP_W-1:0]  step_reg, step_next;
    fecho_pkg::ucode_t             cw;

    logic [fecho_pkg::LEVEL_W-1:0] echo_level_reg;
    logic [fecho_pkg::DLEN_W-1:0]  delay_length_reg;
    logic [fecho_pkg::GAIN_W-1:0]  direct_gain_reg;
    logic [fecho_pkg::GAIN_W-1:0]  feedback_gain_reg;
    logic [fecho_pkg::GAIN_W-1:0]  tap_gain_reg;

    logic [fecho_pkg::PTR_W-1:0]   wp_reg, wp_next;
    logic                          wrap_reg, wrap_next;
    logic                          d_ok_reg, d_ok_next;
    logic signed [fecho_pkg::SMP_W-1:0] x_reg, t1_reg, t2_reg, p0_reg, fb_reg, out_reg;
    logic signed [fecho_pkg::SMP_W-1:0] t1_next, t2_next, p0_next, fb_next, out_next;
    logic                          m_tvalid_reg, m_tvalid_next;

    logic                          run, accept, out_free, cond_ok, step_done, out_fire;
    logic                          mem_we;
    logic [fecho_pkg::GAIN_W-1:0]  lvl;
    logic [fecho_pkg::LEN_W-1:0]   len_c;
    logic [fecho_pkg::LEN_W:0]     wp_x, len_x, rd_x;
    logic [fecho_pkg::PTR_W-1:0]   rd_addr;
    logic [fecho_pkg::SMP_W-1:0]   ram_q;
    logic signed [fecho_pkg::SMP_W-1:0] d_val, p0_calc, q1, q2;
    logic signed [fecho_pkg::SMP_W:0]   a1, b1, a2, b2;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_level_reg    <= '0;
            delay_length_reg  <= 13'd4096;
            direct_gain_reg   <= 15'd9830;
            feedback_gain_reg <= 15'd16384;
            tap_gain_reg      <= 15'd9830;
        end else if (cfg_valid) begin
            case (cfg_index)
                fecho_pkg::REG_ECHO_LEVEL:    echo_level_reg    <= cfg_data[fecho_pkg::LEVEL_W-1:0];
                fecho_pkg::REG_DELAY_LENGTH:  delay_length_reg  <= cfg_data[fecho_pkg::DLEN_W-1:0];
                fecho_pkg::REG_DIRECT_GAIN:   direct_gain_reg   <= cfg_data[fecho_pkg::GAIN_W-1:0];
                fecho_pkg::REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data[fecho_pkg::GAIN_W-1:0];
                fecho_pkg::REG_TAP_GAIN:      tap_gain_reg      <= cfg_data[fecho_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // FSM next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fecho_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = fecho_pkg::ST_RUN;
                end
            end
            fecho_pkg::ST_RUN: begin
                if (step_done) begin
                    state_next = fecho_pkg::ST_IDLE;
                end
            end
            default: state_next = fecho_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready = 1'b0;
        run      = 1'b0;
        case (state_reg)
            fecho_pkg::ST_IDLE: s_tready = 1'b1;
            fecho_pkg::ST_RUN:  run      = 1'b1;
            default: begin
            end
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign cw        = fecho_pkg::ucode_rom(step_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cond_ok   = (cw.cond == fecho_pkg::CND_NONE) || out_free;
    assign step_done = run && cond_ok && cw.last;
    assign out_fire  = run && cw.out_ld && cond_ok;
    assign mem_we    = run && cw.mem_wr;

    always_comb begin
        step_next = step_reg;
        if (!run) begin
            step_next = '0;
        end else if (cond_ok) begin
            step_next = cw.last ? '0 : cw.nxt;
        end
    end

    // delay read address and fill check
    always_comb begin
        if (delay_length_reg == '0) begin
            len_c = fecho_pkg::LEN_W'(1);
        end else if (32'(delay_length_reg) > 32'(fecho_pkg::MAX_DELAY)) begin
            len_c = fecho_pkg::LEN_W'(fecho_pkg::MAX_DELAY);
        end else begin
            len_c = fecho_pkg::LEN_W'(delay_length_reg);
        end
        wp_x  = (fecho_pkg::LEN_W + 1)'(wp_reg);
        len_x = (fecho_pkg::LEN_W + 1)'(len_c);
        if (wp_x >= len_x) begin
            rd_x = wp_x - len_x;
        end else begin
            rd_x = wp_x + (fecho_pkg::LEN_W + 1)'(fecho_pkg::MAX_DELAY) - len_x;
        end
        rd_addr   = rd_x[fecho_pkg::PTR_W-1:0];
        d_ok_next = accept ? (wrap_reg || (rd_addr < wp_reg)) : d_ok_reg;
    end

    fecho_ram #(
        .WIDTH (fecho_pkg::SMP_W),
        .DEPTH (fecho_pkg::MAX_DELAY)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (p0_calc),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign lvl     = fecho_pkg::level_frac(echo_level_reg);
    assign d_val   = d_ok_reg ? $signed(ram_q) : '0;
    assign p0_calc = fecho_pkg::sat_add(x_reg, t1_reg);

    always_comb begin
        case (cw.mul1)
            fecho_pkg::MOP_LVL_FB: begin
                a1 = {2'b00, lvl};
                b1 = {fb_reg[fecho_pkg::SMP_W-1], fb_reg};
            end
            fecho_pkg::MOP_FBG_T1: begin
                a1 = {2'b00, feedback_gain_reg};
                b1 = {t1_reg[fecho_pkg::SMP_W-1], t1_reg};
            end
            fecho_pkg::MOP_DIR_P0: begin
                a1 = {2'b00, direct_gain_reg};
                b1 = {p0_reg[fecho_pkg::SMP_W-1], p0_reg};
            end
            default: begin
                a1 = '0;
                b1 = '0;
            end
        endcase
        case (cw.mul2)
            fecho_pkg::MOP_TAP_D: begin
                a2 = {2'b00, tap_gain_reg};
                b2 = {d_val[fecho_pkg::SMP_W-1], d_val};
            end
            fecho_pkg::MOP_LVL_T2: begin
                a2 = {2'b00, lvl};
                b2 = {t2_reg[fecho_pkg::SMP_W-1], t2_reg};
            end
            default: begin
                a2 = '0;
                b2 = '0;
            end
        endcase
    end

    assign q1 = fecho_pkg::qmul(a1, b1);
    assign q2 = fecho_pkg::qmul(a2, b2);

    always_comb begin
        t1_next       = (run && cw.mul1 != fecho_pkg::MOP_NONE) ? q1 : t1_reg;
        t2_next       = (run && cw.mul2 != fecho_pkg::MOP_NONE) ? q2 : t2_reg;
        fb_next       = (run && cw.fb_ld) ? q2 : fb_reg;
        p0_next       = (run && cw.p0_ld) ? p0_calc : p0_reg;
        out_next      = out_fire ? fecho_pkg::sat_add(q1, t2_reg) : out_reg;
        m_tvalid_next = out_fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        wp_next       = wp_reg;
        wrap_next     = wrap_reg;
        if (mem_we) begin
            if (32'(wp_reg) == fecho_pkg::MAX_DELAY - 1) begin
                wp_next   = '0;
                wrap_next = 1'b1;
            end else begin
                wp_next = wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fecho_pkg::ST_IDLE;
            step_reg     <= '0;
            wp_reg       <= '0;
            wrap_reg     <= 1'b0;
            fb_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            wp_reg       <= wp_next;
            wrap_reg     <= wrap_next;
            fb_reg       <= fb_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= $signed(s_tdata);
        end
        d_ok_reg <= d_ok_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        p0_reg   <= p0_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_idle_step_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fecho_pkg::ST_IDLE) |-> (step_reg == '0))
        else $error("step counter not at zero while idle");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire |-> (!m_tvalid_reg || m_tready))
        else $error("result register loaded while a result waits");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && mem_we))
        else $error("delay memory read and write in the same cycle");

    a_wp_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (wp_reg != $past(wp_reg)))
        else $error("write pointer did not advance after a store");

    a_wrap_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(wrap_reg))
        else $error("wrap flag cleared outside reset");
`endif

endmodule
